[hdl/tobqc_pkg.sv]
// shared types and constants for the top-of-book quote cache
package tobqc_pkg;
   localparam int TableEntriesDefault = 16;
   localparam logic [61:0] StaleGapReset = 62'd250000000;

   typedef enum logic [2:0] {
      STATUS_OK     = 3'd0,
      STATUS_FULL   = 3'd1,
      STATUS_BAD    = 3'd2,
      STATUS_OLDSEQ = 3'd3,
      STATUS_STALE  = 3'd4
   } status_type;

   typedef struct packed {
      logic [62:0] symbol_key;
      logic signed [63:0] bid_price;
      logic signed [63:0] ask_price;
      logic signed [63:0] bid_quantity;
      logic signed [63:0] ask_quantity;
      logic [62:0] timestamp_ns;
      logic [63:0] sequence_number;
   } quote_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        notified;
      logic [4:0]  entry_index;
      logic [63:0] entry_updates;
      logic [63:0] entry_rejects;
      logic [63:0] total_notified;
      logic [63:0] total_rejected;
      logic [4:0]  entries_used;
   } result_type;

   // stored record of one slot
   typedef struct packed {
      logic signed [63:0] bid_price;
      logic signed [63:0] ask_price;
      logic signed [63:0] bid_quantity;
      logic signed [63:0] ask_quantity;
      logic [63:0] timestamp;
      logic [63:0] sequence_number;
      logic [63:0] update_count;
      logic [63:0] reject_count;
   } slot_type;
endpackage

[hdl/tobqc_channel_if.sv]
// valid/ready channels for quotes, results and the csr write
interface tobqc_req_if;
   import tobqc_pkg::*;
   logic valid;
   logic ready;
   quote_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tobqc_rsp_if;
   import tobqc_pkg::*;
   logic valid;
   logic ready;
   result_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tobqc_csr_if;
   logic valid;
   logic ready;
   logic [61:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hdl/top_of_book_quote_cache_unit.sv]
// top-of-book quote cache: key match, slot memory read-modify-write, result register
// Usage:
//  req carries one parsed quote tick per beat; rsp returns one result per tick.
//  csr writes the 62-bit stale gap; write only while the block is idle.
//  A tick is matched against the instrument keys held in flip-flops in the
//  accept cycle; the slot record is read from a one-port synchronous memory
//  into a register, then checked and written back in the cycle in which the
//  result is loaded into the output register, once that register can take it.
//  Ticks are processed one at a time: the memory read and the write back use
//  the same port, and a new tick is accepted only after the write back.
//  A new tick is accepted while a finished result waits in the output
//  register, but the result register must be free before the write back.
//  If rsp stalls, the block holds its result and stops after one more tick.
//  Reset clears slot valid bits, entry count, totals and the stale gap to
//  250000000; slot records need no clear, a new slot is zeroed on allocation.
module top_of_book_quote_cache_unit
   import tobqc_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault
) (
   input logic clock,
   input logic reset,
   tobqc_req_if.sink req,
   tobqc_rsp_if.source rsp,
   tobqc_csr_if.sink csr
);
   localparam int IW = $clog2(TABLE_ENTRIES + 1);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [61:0] gap_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [62:0] key_ff [TABLE_ENTRIES];
   logic [IW-1:0] used_ff;
   logic [63:0] ntot_ff, rtot_ff;
   slot_type mem [TABLE_ENTRIES];
   slot_type rd_ff;

   logic busy_ff;           // tick in check and write-back stage
   quote_type q_ff;
   logic [AW-1:0] slot_ff;
   logic hit_ff, fresh_ff;  // fresh: key missed (new slot or table full), treat record as zero
   logic out_valid_ff;
   result_type out_ff;

   // key match
   logic hit_in;
   logic [AW-1:0] idx_hit;
   always_comb begin
      hit_in = 1'b0;
      idx_hit = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req.data.symbol_key) begin
            hit_in = 1'b1;
            idx_hit = AW'(i);
         end
      end
   end

   logic can_write;
   assign can_write = !out_valid_ff || rsp.ready;
   assign req.ready = !busy_ff;
   assign csr.ready = 1'b1;
   logic acc;
   assign acc = req.valid && req.ready;
   logic room;
   assign room = used_ff < IW'(TABLE_ENTRIES);

   always_ff @(posedge clock) begin
      if (acc) rd_ff <= mem[hit_in ? idx_hit : used_ff[AW-1:0]];
   end

   // second stage: checks
   slot_type cur, nxt;
   logic [2:0] st;
   logic notif, bad;
   logic [63:0] tsum;
   always_comb begin
      cur = fresh_ff ? '0 : rd_ff;
      bad = q_ff.bid_price <= 0 || q_ff.ask_price <= 0 ||
            q_ff.bid_price >= q_ff.ask_price || q_ff.bid_quantity < 0 ||
            q_ff.ask_quantity < 0 ||
            (q_ff.bid_quantity == 0 && q_ff.ask_quantity == 0);
      tsum = {1'b0, q_ff.timestamp_ns} + {2'b0, gap_ff};
      if (!hit_ff) st = STATUS_FULL;
      else if (bad) st = STATUS_BAD;
      else if (q_ff.sequence_number <= cur.sequence_number) st = STATUS_OLDSEQ;
      else if (tsum < cur.timestamp) st = STATUS_STALE;
      else st = STATUS_OK;
      nxt = cur;
      notif = 1'b0;
      if (st == STATUS_OK) begin
         notif = (cur.bid_price != q_ff.bid_price || cur.ask_price != q_ff.ask_price ||
                  cur.bid_quantity != q_ff.bid_quantity ||
                  cur.ask_quantity != q_ff.ask_quantity) &&
                 (q_ff.bid_quantity > 0 || q_ff.ask_quantity > 0);
         nxt.bid_price = q_ff.bid_price;
         nxt.ask_price = q_ff.ask_price;
         nxt.bid_quantity = q_ff.bid_quantity;
         nxt.ask_quantity = q_ff.ask_quantity;
         nxt.timestamp = {1'b0, q_ff.timestamp_ns};
         nxt.sequence_number = q_ff.sequence_number;
         nxt.update_count = cur.update_count + 64'd1;
      end else begin
         nxt.reject_count = cur.reject_count + 64'd1;
      end
   end

   logic fin;
   assign fin = busy_ff && can_write;

   always_ff @(posedge clock) begin
      if (fin && hit_ff) mem[slot_ff] <= nxt;
      if (acc) q_ff <= req.data;
      if (acc && !hit_in && room) key_ff[used_ff[AW-1:0]] <= req.data.symbol_key;
      if (acc) begin
         hit_ff <= hit_in || room;
         fresh_ff <= !hit_in;
         slot_ff <= hit_in ? idx_hit : used_ff[AW-1:0];
      end
      if (fin) begin
         out_ff.status <= st;
         out_ff.notified <= notif;
         out_ff.entry_index <= hit_ff ? 5'(slot_ff) : 5'(TABLE_ENTRIES);
         out_ff.entry_updates <= hit_ff ? nxt.update_count : '0;
         out_ff.entry_rejects <= hit_ff ? nxt.reject_count : '0;
         out_ff.total_notified <= ntot_ff + 64'(notif);
         out_ff.total_rejected <= rtot_ff + 64'(st != STATUS_OK);
         out_ff.entries_used <= 5'(used_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= StaleGapReset;
         valid_ff <= '0;
         used_ff <= '0;
         ntot_ff <= '0;
         rtot_ff <= '0;
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) gap_ff <= csr.data;
         if (acc) busy_ff <= 1'b1;
         else if (fin) busy_ff <= 1'b0;
         if (acc && !hit_in && room) begin
            valid_ff[used_ff[AW-1:0]] <= 1'b1;
            used_ff <= used_ff + IW'(1);
         end
         if (fin) begin
            ntot_ff <= ntot_ff + 64'(notif);
            rtot_ff <= rtot_ff + 64'(st != STATUS_OK);
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= IW'(TABLE_ENTRIES)) else $error("entry count overflow");
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(used_ff)) else $error("valid bits disagree with count");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !fin |=> busy_ff) else $error("tick dropped");
   a_notif_ok: assert property (@(posedge clock) disable iff (reset)
      fin && notif |-> st == STATUS_OK) else $error("notify on reject");
endmodule
